>>> hw/rtl/expiring_mailbox_table_top_assert.svh
// Assertion macros for the expiring mailbox table.
`ifndef EXPIRING_MAILBOX_TABLE_TOP_ASSERT_SVH
`define EXPIRING_MAILBOX_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EMT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define EMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EMT_ASSERT(lbl, clk, rstn, prop)
`define EMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/emt_pkg.sv
// Shared types and constants of the expiring mailbox table.
package emt_pkg;

  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned PAYLOAD_DEF     = 8;
  localparam int unsigned MAX_CLIENTS_DEF = 64;
  localparam logic [31:0] EXPIRY_RESET    = 32'd1000;

  typedef enum logic [2:0] {
    OP_CONNECT    = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_POST       = 3'd2,
    OP_READ       = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_EMPTY     = 4'd1,
    ST_OWN       = 4'd2,
    ST_NOT_ADDR  = 4'd3,
    ST_EXPIRED   = 4'd4,
    ST_READ_DONE = 4'd5,
    ST_FULL      = 4'd6,
    ST_NOT_CONN  = 4'd7,
    ST_NO_IDS    = 4'd8
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_POST_WR, S_CONT_RD, S_CONT_WR,
    S_READ_CHK, S_EMIT_RD, S_EMIT_WR, S_RESP
  } state_e;

endpackage

>>> hw/rtl/emt_req_if.sv
// Request channel of the expiring mailbox table.
interface emt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [5:0]  client_id;
  logic [31:0] sender_id;
  logic [31:0] dest_id;
  logic [3:0]  box_index;
  logic [47:0] now_ms;
  logic [63:0] data_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, operation, client_id, sender_id, dest_id, box_index,
                  now_ms, data_word, word_index, last_word, input ready);
  modport sink (input valid, operation, client_id, sender_id, dest_id, box_index,
                now_ms, data_word, word_index, last_word, output ready);
endinterface

>>> hw/rtl/emt_rsp_if.sv
// Result channel of the expiring mailbox table.
interface emt_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [5:0]  assigned_id;
  logic [6:0]  observer_count;
  logic [47:0] msg_stamp;
  logic [31:0] msg_sender;
  logic [31:0] msg_dest;
  logic [63:0] payload_word;
  logic [2:0]  payload_index;
  logic        last;
  modport source (output valid, status, assigned_id, observer_count, msg_stamp, msg_sender,
                  msg_dest, payload_word, payload_index, last, input ready);
  modport sink (input valid, status, assigned_id, observer_count, msg_stamp, msg_sender,
                msg_dest, payload_word, payload_index, last, output ready);
endinterface

>>> hw/rtl/emt_cfg_if.sv
// Configuration write channel of the expiring mailbox table.
interface emt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/expiring_mailbox_table_top.sv
// Top level of the expiring mailbox table.
//
//  Channel | Direction | Moves
//  req_i   | in        | one request: connect, disconnect, post word, read slot, query
//  rsp_o   | out       | one result; a good read gives one result per payload word
//  cfg_i   | in        | a new message lifetime in milliseconds
//
// Requests are taken one at a time; the next one is accepted once the block is idle again.
// A post start scans the header memory one slot a cycle and stops at the first free slot
// or after the last one. A good read gives one result per payload word, and the payload
// memory port is read once per word. Reset is asynchronous and clears all slots at once
// through per-slot valid bits, so no clearing pass is needed. A stalled result holds the
// block in place.
`include "expiring_mailbox_table_top_assert.svh"
module expiring_mailbox_table_top import emt_pkg::*; #(
  parameter int unsigned SLOTS         = SLOTS_DEF,
  parameter int unsigned PAYLOAD_WORDS = PAYLOAD_DEF,
  parameter int unsigned MAX_CLIENTS   = MAX_CLIENTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  emt_req_if.sink   req_i,
  emt_rsp_if.source rsp_o,
  emt_cfg_if.sink   cfg_i
);
  // Widths derived from the parameters.
  localparam int unsigned SW  = $clog2(SLOTS);
  localparam int unsigned KW  = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
  localparam int unsigned PD  = SLOTS * PAYLOAD_WORDS;
  localparam int unsigned PAW = $clog2(PD);
  localparam int unsigned CIW = $clog2(MAX_CLIENTS);
  localparam int unsigned NCW = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned HW  = 48 + 32 + 32 + 64 + PAYLOAD_WORDS;

  // Captured request.
  op_e         op_q;
  logic [5:0]  cid_q;
  logic [31:0] sid_q, did_q;
  logic [3:0]  box_q;
  logic [47:0] now_q;
  logic [63:0] word_q;
  logic [2:0]  widx_q;
  logic        lastw_q;

  state_e state_q, state_d;

  // Global state.
  logic [31:0]            expiry_q;
  logic [NCW-1:0]         next_client_q;
  logic [6:0]             observer_q;
  logic [MAX_CLIENTS-1:0] conn_mask_q;
  logic [SW:0]            post_slot_q;
  logic [SLOTS-1:0]       slot_vld_q;

  // Sequencing registers.
  logic [SW:0]   cnt_q;
  logic [SW-1:0] rd_idx_q;
  logic          rd_ok_q;
  logic [SW-1:0] hidx_q;
  logic [KW-1:0] k_q;
  status_e       rsp_status_q;
  logic [5:0]    rsp_id_q;

  // Header of the message being read.
  logic [47:0]              m_time_q;
  logic [31:0]              m_sender_q, m_dest_q;
  logic [PAYLOAD_WORDS-1:0] m_wmask_q;

  // Output register.
  logic        out_valid_q;
  logic [3:0]  out_status_q;
  logic [5:0]  out_id_q;
  logic [6:0]  out_obs_q;
  logic [47:0] out_time_q;
  logic [31:0] out_sender_q, out_dest_q;
  logic [63:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  // Memory ports.
  logic          hdr_we, hdr_re;
  logic [SW-1:0] hdr_waddr, hdr_raddr;
  logic [HW-1:0] hdr_wdata, hdr_rdata, hdr_eff;
  logic           pay_we, pay_re;
  logic [PAW-1:0] pay_waddr, pay_raddr;
  logic [63:0]    pay_rdata;

  // Fields of the header just read; an invalid slot reads as all zero.
  logic [47:0]              h_time;
  logic [31:0]              h_sender, h_dest;
  logic [63:0]              h_rmask;
  logic [PAYLOAD_WORDS-1:0] h_wmask;

  logic out_free, req_fire, cfg_fire;
  logic scan_free, chk_expired, cont_in_range, emit_last;

  function automatic logic [PAW-1:0] pay_addr(logic [SW-1:0] s, logic [KW-1:0] k);
    pay_addr = PAW'(s) * PAW'(PAYLOAD_WORDS) + PAW'(k);
  endfunction

  // A slot is expired once its age reaches the lifetime; a later post time is never expired.
  function automatic logic is_expired(logic [47:0] now, logic [47:0] t, logic [31:0] lim);
    is_expired = (now >= t) && ((now - t) >= {16'd0, lim});
  endfunction

  emt_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_hdr_ram (
    .clk_i, .we_i(hdr_we), .waddr_i(hdr_waddr), .wdata_i(hdr_wdata),
    .re_i(hdr_re), .raddr_i(hdr_raddr), .rdata_o(hdr_rdata)
  );

  emt_ram #(.WIDTH(64), .DEPTH(PD)) u_pay_ram (
    .clk_i, .we_i(pay_we), .waddr_i(pay_waddr), .wdata_i(word_q),
    .re_i(pay_re), .raddr_i(pay_raddr), .rdata_o(pay_rdata)
  );

  // The header read always belongs to the index held in rd_idx_q or hidx_q;
  // the scan checks the valid bit of rd_idx_q, every other state that of hidx_q.
  assign hdr_eff  = (state_q == S_SCAN) ? (slot_vld_q[rd_idx_q] ? hdr_rdata : '0)
                                        : (slot_vld_q[hidx_q] ? hdr_rdata : '0);
  assign h_time   = hdr_eff[47:0];
  assign h_sender = hdr_eff[79:48];
  assign h_dest   = hdr_eff[111:80];
  assign h_rmask  = hdr_eff[175:112];
  assign h_wmask  = hdr_eff[HW-1:176];

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_fire  = req_i.valid && req_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign scan_free     = rd_ok_q && ((h_time == 48'd0) || is_expired(now_q, h_time, expiry_q));
  assign chk_expired   = is_expired(now_q, h_time, expiry_q);
  assign cont_in_range = ({4'd0, widx_q} < 7'(PAYLOAD_WORDS));
  assign emit_last     = (k_q == KW'(PAYLOAD_WORDS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_fire) state_d = S_EXEC;
      S_EXEC: begin
        if (op_q == OP_POST && widx_q == 3'd0) begin
          state_d = S_SCAN;
        end else if (op_q == OP_POST && post_slot_q != '0 && cont_in_range) begin
          state_d = S_CONT_RD;
        end else if (op_q == OP_READ && {5'd0, box_q} < 9'(SLOTS)) begin
          state_d = S_READ_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_free) begin
          state_d = S_POST_WR;
        end else if (rd_ok_q && rd_idx_q == SW'(SLOTS - 1)) begin
          state_d = S_RESP;
        end
      end
      S_POST_WR: state_d = S_RESP;
      S_CONT_RD: state_d = S_CONT_WR;
      S_CONT_WR: state_d = S_RESP;
      S_READ_CHK: begin
        priority if (h_time == 48'd0 || h_sender == sid_q ||
                     (h_dest != 32'd0 && h_dest != sid_q) || chk_expired ||
                     h_rmask[cid_q]) begin
          state_d = S_RESP;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD: state_d = S_EMIT_WR;
      S_EMIT_WR: if (out_free) state_d = emit_last ? S_IDLE : S_EMIT_RD;
      S_RESP:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    hdr_we    = 1'b0;
    hdr_re    = 1'b0;
    hdr_waddr = hidx_q;
    hdr_raddr = hidx_q;
    hdr_wdata = hdr_eff;
    pay_we    = 1'b0;
    pay_re    = 1'b0;
    pay_waddr = pay_addr(hidx_q, KW'(widx_q));
    pay_raddr = pay_addr(hidx_q, k_q);
    unique case (state_q)
      S_EXEC: begin
        hdr_re    = (op_q == OP_READ);
        hdr_raddr = SW'(box_q);
      end
      S_SCAN: begin
        hdr_re    = !scan_free && (cnt_q < (SW + 1)'(SLOTS));
        hdr_raddr = cnt_q[SW-1:0];
      end
      S_POST_WR: begin
        hdr_we    = 1'b1;
        hdr_wdata = {PAYLOAD_WORDS'(1), 64'd0, did_q, sid_q, now_q};
        pay_we    = 1'b1;
        pay_waddr = pay_addr(hidx_q, '0);
      end
      S_CONT_RD: begin
        hdr_re    = 1'b1;
      end
      S_CONT_WR: begin
        hdr_we    = 1'b1;
        hdr_wdata = {h_wmask | (PAYLOAD_WORDS'(1) << KW'(widx_q)), hdr_eff[175:0]};
        pay_we    = 1'b1;
      end
      S_READ_CHK: begin
        hdr_we    = (state_d == S_EMIT_RD);
        hdr_wdata = {h_wmask, h_rmask | (64'd1 << cid_q), hdr_eff[111:0]};
      end
      S_EMIT_RD: pay_re = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      expiry_q      <= EXPIRY_RESET;
      next_client_q <= '0;
      observer_q    <= '0;
      conn_mask_q   <= '0;
      post_slot_q   <= '0;
      slot_vld_q    <= '0;
      out_valid_q   <= 1'b0;
      rd_ok_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) expiry_q <= cfg_i.data;
      // A new result takes the output register; otherwise an accepted one leaves it.
      if ((state_q == S_RESP || state_q == S_EMIT_WR) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_EXEC: begin
          rd_ok_q <= 1'b0;
          if (op_q == OP_CONNECT && next_client_q < NCW'(MAX_CLIENTS)) begin
            next_client_q <= next_client_q + 1'b1;
            observer_q    <= observer_q + 1'b1;
            conn_mask_q[next_client_q[CIW-1:0]] <= 1'b1;
          end
          if (op_q == OP_DISCONNECT && {1'b0, cid_q} < 7'(MAX_CLIENTS) &&
              conn_mask_q[cid_q[CIW-1:0]]) begin
            conn_mask_q[cid_q[CIW-1:0]] <= 1'b0;
            if (observer_q != 7'd0) observer_q <= observer_q - 1'b1;
          end
          if (op_q == OP_POST) begin
            if (widx_q == 3'd0 || post_slot_q == '0) begin
              post_slot_q <= '0;
            end else if (!cont_in_range && lastw_q) begin
              post_slot_q <= '0;
            end
          end
        end
        S_SCAN: rd_ok_q <= hdr_re;
        S_POST_WR: begin
          slot_vld_q[hidx_q] <= 1'b1;
          post_slot_q <= lastw_q ? '0 : {1'b0, hidx_q} + 1'b1;
        end
        S_CONT_WR: begin
          slot_vld_q[hidx_q] <= 1'b1;
          if (lastw_q) post_slot_q <= '0;
        end
        S_READ_CHK: begin
          // An expired message is dropped by invalidating its slot.
          if (h_time != 48'd0 && h_sender != sid_q &&
              !(h_dest != 32'd0 && h_dest != sid_q) && chk_expired) begin
            slot_vld_q[hidx_q] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= op_e'(req_i.operation);
      cid_q   <= req_i.client_id;
      sid_q   <= req_i.sender_id;
      did_q   <= req_i.dest_id;
      box_q   <= req_i.box_index;
      now_q   <= req_i.now_ms;
      word_q  <= req_i.data_word;
      widx_q  <= req_i.word_index;
      lastw_q <= req_i.last_word;
    end
    unique case (state_q)
      S_EXEC: begin
        cnt_q        <= '0;
        hidx_q       <= (op_q == OP_READ) ? SW'(box_q) : post_slot_q[SW-1:0] - 1'b1;
        unique case (op_q)
          OP_CONNECT: begin
            if (next_client_q < NCW'(MAX_CLIENTS)) begin
              rsp_status_q <= ST_OK;
              rsp_id_q     <= 6'(next_client_q);
            end else begin
              rsp_status_q <= ST_NO_IDS;
              rsp_id_q     <= '0;
            end
          end
          OP_DISCONNECT: begin
            rsp_id_q <= '0;
            if (!({1'b0, cid_q} < 7'(MAX_CLIENTS) && conn_mask_q[cid_q[CIW-1:0]])) begin
              rsp_status_q <= ST_NOT_CONN;
            end else begin
              rsp_status_q <= ST_OK;
            end
          end
          OP_POST: begin
            rsp_id_q     <= '0;
            rsp_status_q <= (widx_q != 3'd0 && post_slot_q == '0) ? ST_FULL : ST_OK;
          end
          OP_READ: begin
            rsp_id_q     <= '0;
            rsp_status_q <= ({5'd0, box_q} < 9'(SLOTS)) ? ST_OK : ST_EMPTY;
          end
          default: begin
            rsp_id_q     <= '0;
            rsp_status_q <= ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        if (hdr_re) begin
          cnt_q    <= cnt_q + 1'b1;
          rd_idx_q <= cnt_q[SW-1:0];
        end
        if (scan_free) hidx_q <= rd_idx_q;
        else if (rd_ok_q && rd_idx_q == SW'(SLOTS - 1)) rsp_status_q <= ST_FULL;
      end
      S_READ_CHK: begin
        priority if (h_time == 48'd0) rsp_status_q <= ST_EMPTY;
        else if (h_sender == sid_q) rsp_status_q <= ST_OWN;
        else if (h_dest != 32'd0 && h_dest != sid_q) rsp_status_q <= ST_NOT_ADDR;
        else if (chk_expired) rsp_status_q <= ST_EXPIRED;
        else if (h_rmask[cid_q]) rsp_status_q <= ST_READ_DONE;
        else rsp_status_q <= ST_OK;
        m_time_q   <= h_time;
        m_sender_q <= h_sender;
        m_dest_q   <= h_dest;
        m_wmask_q  <= h_wmask;
        k_q        <= '0;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_status_q <= ST_OK;
          out_id_q     <= '0;
          out_obs_q    <= observer_q;
          out_time_q   <= m_time_q;
          out_sender_q <= m_sender_q;
          out_dest_q   <= m_dest_q;
          // Words never written since the post started read as zero.
          out_word_q   <= m_wmask_q[k_q] ? pay_rdata : 64'd0;
          out_idx_q    <= 3'(k_q);
          out_last_q   <= emit_last;
          k_q          <= k_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_status_q <= rsp_status_q;
          out_id_q     <= rsp_id_q;
          out_obs_q    <= observer_q;
          out_time_q   <= '0;
          out_sender_q <= '0;
          out_dest_q   <= '0;
          out_word_q   <= '0;
          out_idx_q    <= '0;
          out_last_q   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.assigned_id    = out_id_q;
  assign rsp_o.observer_count = out_obs_q;
  assign rsp_o.msg_stamp      = out_time_q;
  assign rsp_o.msg_sender     = out_sender_q;
  assign rsp_o.msg_dest       = out_dest_q;
  assign rsp_o.payload_word   = out_word_q;
  assign rsp_o.payload_index  = out_idx_q;
  assign rsp_o.last           = out_last_q;

  // The observer count can never pass the number of ids handed out.
  `EMT_ASSERT(a_obs_le_ids, clk_i, rst_ni, NCW'(observer_q) <= next_client_q)
  // An open post always names a slot that exists.
  `EMT_ASSERT(a_post_slot_range, clk_i, rst_ni, post_slot_q <= (SW + 1)'(SLOTS))
  // Only one request is in the block at a time.
  `EMT_ASSERT_NEXT(a_one_request, clk_i, rst_ni, req_fire, !req_i.ready)
endmodule

>>> hw/rtl/emt_ram.sv
// Generic single-port-write, registered-read RAM.
module emt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> tb/tb.sv
// Self-checking testbench for the expiring mailbox table.
`timescale 1ns / 100ps
module tb;
  import emt_pkg::*;

  localparam int unsigned NSLOT  = SLOTS_DEF;
  localparam int unsigned NWORD  = PAYLOAD_DEF;
  localparam int unsigned NCLI   = MAX_CLIENTS_DEF;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 64;

  // One result as the block should present it.
  typedef struct {
    logic [3:0]  status;
    logic [5:0]  assigned_id;
    logic [6:0]  observer_count;
    logic [47:0] msg_stamp;
    logic [31:0] msg_sender;
    logic [31:0] msg_dest;
    logic [63:0] payload_word;
    logic [2:0]  payload_index;
    logic        last;
  } result_t;

  // One request as offered to the block.
  typedef struct {
    op_e         operation;
    logic [5:0]  client_id;
    logic [31:0] sender_id;
    logic [31:0] dest_id;
    logic [3:0]  box_index;
    logic [47:0] now_ms;
    logic [63:0] data_word;
    logic [2:0]  word_index;
    logic        last_word;
  } request_t;

  // The scoreboard keeps its own copy of the mailbox table and the queue of
  // results that the accepted requests are owed.
  class mailbox_scoreboard;
    logic [47:0] box_time [NSLOT];
    logic [63:0] box_seen [NSLOT];
    logic [31:0] box_from [NSLOT];
    logic [31:0] box_to   [NSLOT];
    logic [63:0] box_words[NSLOT][NWORD];
    int unsigned next_id;
    int unsigned observers;
    logic [63:0] connected;
    int unsigned open_slot;
    logic [31:0] lifetime;
    result_t     owed[$];
    int unsigned errors;
    int unsigned good_reads;
    int unsigned checked;

    function new();
      for (int s = 0; s < NSLOT; s++) wipe(s);
      next_id = 0;
      observers = 0;
      connected = '0;
      open_slot = 0;
      lifetime = EXPIRY_RESET;
      errors = 0;
      good_reads = 0;
      checked = 0;
    endfunction

    function void wipe(int s);
      box_time[s] = '0;
      box_seen[s] = '0;
      box_from[s] = '0;
      box_to[s] = '0;
      for (int k = 0; k < NWORD; k++) box_words[s][k] = '0;
    endfunction

    function bit aged(int s, logic [47:0] now);
      return now >= box_time[s] && (now - box_time[s]) >= {16'd0, lifetime};
    endfunction

    function void owe(status_e st, logic [5:0] id);
      result_t r;
      r = '{default: '0};
      r.status = st;
      r.assigned_id = id;
      r.observer_count = observers[6:0];
      r.last = 1'b1;
      owed.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the table.
    function void note_request(request_t q);
      logic [63:0] bit_of;
      int s;
      result_t r;
      bit_of = 64'd1 << q.client_id;
      case (q.operation)
        OP_CONNECT: begin
          if (next_id >= NCLI) owe(ST_NO_IDS, '0);
          else begin
            connected[next_id] = 1'b1;
            observers++;
            next_id++;
            owe(ST_OK, 6'(next_id - 1));
          end
        end
        OP_DISCONNECT: begin
          if (!connected[q.client_id]) owe(ST_NOT_CONN, '0);
          else begin
            connected &= ~bit_of;
            if (observers > 0) observers--;
            owe(ST_OK, '0);
          end
        end
        OP_POST: begin
          if (q.word_index == 0) begin
            open_slot = 0;
            for (s = 0; s < NSLOT; s++)
              if (box_time[s] == 0 || aged(s, q.now_ms)) break;
            if (s >= NSLOT) owe(ST_FULL, '0);
            else begin
              wipe(s);
              box_time[s] = q.now_ms;
              box_from[s] = q.sender_id;
              box_to[s] = q.dest_id;
              box_words[s][0] = q.data_word;
              open_slot = q.last_word ? 0 : s + 1;
              owe(ST_OK, '0);
            end
          end else if (open_slot == 0) begin
            owe(ST_FULL, '0);
          end else begin
            if (q.word_index < NWORD) box_words[open_slot - 1][q.word_index] = q.data_word;
            if (q.last_word) open_slot = 0;
            owe(ST_OK, '0);
          end
        end
        OP_READ: begin
          s = q.box_index;
          if (s >= NSLOT || box_time[s] == 0) owe(ST_EMPTY, '0);
          else if (box_from[s] == q.sender_id) owe(ST_OWN, '0);
          else if (box_to[s] != 0 && box_to[s] != q.sender_id) owe(ST_NOT_ADDR, '0);
          else if (aged(s, q.now_ms)) begin
            wipe(s);
            owe(ST_EXPIRED, '0);
          end else if (box_seen[s] & bit_of) owe(ST_READ_DONE, '0);
          else begin
            box_seen[s] |= bit_of;
            good_reads++;
            for (int k = 0; k < NWORD; k++) begin
              r.status = ST_OK;
              r.assigned_id = '0;
              r.observer_count = observers[6:0];
              r.msg_stamp = box_time[s];
              r.msg_sender = box_from[s];
              r.msg_dest = box_to[s];
              r.payload_word = box_words[s][k];
              r.payload_index = 3'(k);
              r.last = (k + 1 == NWORD);
              owed.push_back(r);
            end
          end
        end
        default: owe(ST_OK, '0);
      endcase
    endfunction

    // Compares one accepted result with the oldest one still owed.
    function void check_result(result_t got);
      result_t want;
      checked++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.assigned_id != want.assigned_id) begin
        $display("%0t: assigned_id expected %0d actual %0d", $time, want.assigned_id,
                 got.assigned_id);
        errors++;
      end
      if (got.observer_count != want.observer_count) begin
        $display("%0t: observer_count expected %0d actual %0d", $time,
                 want.observer_count, got.observer_count);
        errors++;
      end
      if (got.msg_stamp != want.msg_stamp) begin
        $display("%0t: msg_stamp expected %h actual %h", $time, want.msg_stamp,
                 got.msg_stamp);
        errors++;
      end
      if (got.msg_sender != want.msg_sender) begin
        $display("%0t: msg_sender expected %h actual %h", $time, want.msg_sender,
                 got.msg_sender);
        errors++;
      end
      if (got.msg_dest != want.msg_dest) begin
        $display("%0t: msg_dest expected %h actual %h", $time, want.msg_dest, got.msg_dest);
        errors++;
      end
      if (got.payload_word != want.payload_word) begin
        $display("%0t: payload_word expected %h actual %h", $time, want.payload_word,
                 got.payload_word);
        errors++;
      end
      if (got.payload_index != want.payload_index) begin
        $display("%0t: payload_index expected %0d actual %0d", $time, want.payload_index,
                 got.payload_index);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  emt_req_if req_ch();
  emt_rsp_if rsp_ch();
  emt_cfg_if cfg_ch();

  expiring_mailbox_table_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  mailbox_scoreboard board = new();

  // The receiver stalls on its own pattern; long_hold forces a long stretch
  // of back-pressure so that the block stalls and stops taking new requests.
  bit long_hold = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned idle_cycles = 0;
  bit timed_out = 1'b0;

  // Sender clock of the current time, which mostly moves forward but now
  // and then jumps back so that the time-reversal rule is exercised.
  logic [47:0] clock_ms = 48'd5000;
  logic [31:0] senders[4] = '{32'h11, 32'h22, 32'h33, 32'hFFFF_FFFF};
  int unsigned sent = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.operation = OP_QUERY;
    req_ch.client_id = '0;
    req_ch.sender_id = '0;
    req_ch.dest_id = '0;
    req_ch.box_index = '0;
    req_ch.now_ms = '0;
    req_ch.data_word = '0;
    req_ch.word_index = '0;
    req_ch.last_word = 1'b0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // Result side: ready follows a pattern that changes per phase, and
  // every accepted result is checked at the edge it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_result('{rsp_ch.status, rsp_ch.assigned_id, rsp_ch.observer_count,
                             rsp_ch.msg_stamp, rsp_ch.msg_sender, rsp_ch.msg_dest,
                             rsp_ch.payload_word, rsp_ch.payload_index, rsp_ch.last});
      if (long_hold) rsp_ch.ready <= 1'b0;
      else case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= ($urandom_range(3, 0) != 0);
        default: rsp_ch.ready <= ($urandom_range(1, 0) == 1);
      endcase
    end
  end

  // Watchdog: counts cycles in which no channel moves a transfer.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one request and holds it until the block accepts it.
  task automatic send_request(request_t q);
    req_ch.valid <= 1'b1;
    req_ch.operation <= q.operation;
    req_ch.client_id <= q.client_id;
    req_ch.sender_id <= q.sender_id;
    req_ch.dest_id <= q.dest_id;
    req_ch.box_index <= q.box_index;
    req_ch.now_ms <= q.now_ms;
    req_ch.data_word <= q.data_word;
    req_ch.word_index <= q.word_index;
    req_ch.last_word <= q.last_word;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(q);
    sent++;
  endtask

  // Drops valid unless the next request follows straight on.
  task automatic idle_gap(int unsigned cycles);
    if (cycles > 0) begin
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Waits until every owed result has come, then lets the block settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.owed.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lifetime(logic [31:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.lifetime = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic request_t blank(op_e op);
    request_t q;
    q = '{operation: op, default: '0};
    q.now_ms = clock_ms;
    return q;
  endfunction

  function automatic request_t post_word(logic [31:0] from, logic [31:0] to,
                                         logic [2:0] idx, logic fin);
    request_t q;
    q = blank(OP_POST);
    q.sender_id = from;
    q.dest_id = to;
    q.word_index = idx;
    q.last_word = fin;
    q.data_word = {$urandom, $urandom};
    return q;
  endfunction

  function automatic request_t read_box(logic [31:0] who, logic [5:0] cid, logic [3:0] box);
    request_t q;
    q = blank(OP_READ);
    q.sender_id = who;
    q.client_id = cid;
    q.box_index = box;
    return q;
  endfunction

  // A well-formed message of the given length, sent back to back.
  task automatic send_message(logic [31:0] from, logic [31:0] to, int unsigned words);
    for (int unsigned k = 0; k < words; k++)
      send_request(post_word(from, to, 3'(k), k + 1 == words));
  endtask

  // One random request: mostly posts and reads with sensible content,
  // the rest connects, disconnects, queries and broken sequences.
  task automatic random_request();
    request_t q;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    clock_ms = ($urandom_range(19, 0) == 0) ? clock_ms - $urandom_range(300, 0)
                                            : clock_ms + $urandom_range(60, 0);
    if (pick < 35) begin
      send_message(senders[$urandom_range(3, 0)],
                   ($urandom_range(1, 0) ? 32'd0 : senders[$urandom_range(3, 0)]),
                   $urandom_range(NWORD, 1));
    end else if (pick < 75) begin
      send_request(read_box(senders[$urandom_range(3, 0)], 6'($urandom_range(7, 0)),
                            4'($urandom_range(NSLOT - 1, 0))));
    end else if (pick < 82) begin
      send_request(blank(OP_CONNECT));
    end else if (pick < 88) begin
      q = blank(OP_DISCONNECT);
      q.client_id = 6'($urandom_range(NCLI - 1, 0));
      send_request(q);
    end else if (pick < 92) begin
      send_request(blank(OP_QUERY));
    end else begin
      // Noise: every field random, including unused operation codes.
      q.operation = op_e'($urandom_range(7, 0));
      q.client_id = 6'($urandom);
      q.sender_id = $urandom;
      q.dest_id = $urandom;
      q.box_index = 4'($urandom);
      q.now_ms = {16'($urandom), $urandom};
      q.data_word = {$urandom, $urandom};
      q.word_index = 3'($urandom);
      q.last_word = 1'($urandom);
      send_request(q);
    end
  endtask

  // Bursts of random requests; valid is dropped at the end so that nothing
  // stays on offer once the phase is over.
  task automatic random_phase(int unsigned count);
    int unsigned burst;
    int unsigned done;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(12, 1);
      for (int unsigned i = 0; i < burst && done < count; i++) begin
        random_request();
        done++;
      end
      idle_gap($urandom_range(1, 0) ? 0 : $urandom_range(20, 1));
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    request_t q;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every operation, the field extremes and each corner of
    // the read checks, at the reset lifetime.
    send_request(blank(OP_QUERY));
    q = blank(OP_DISCONNECT);
    q.client_id = 6'd63;
    send_request(q);                                    // not connected
    send_request(blank(OP_CONNECT));
    send_request(blank(OP_CONNECT));
    q = blank(OP_DISCONNECT);
    send_request(q);                                    // id 0 leaves
    send_request(read_box(32'h22, 6'd1, 4'd15));        // empty slot
    send_request(post_word(32'h11, 32'h0, 3'd3, 1'b1)); // continuation, none open
    send_message(32'h11, 32'h0, NWORD);                 // broadcast into slot 0
    send_request(read_box(32'h11, 6'd1, 4'd0));         // own message
    send_request(read_box(32'h22, 6'd1, 4'd0));         // good read
    send_request(read_box(32'h22, 6'd1, 4'd0));         // already read
    send_message(32'hFFFF_FFFF, 32'h33, 2);             // addressed to 0x33
    send_request(read_box(32'h22, 6'd63, 4'd1));        // not addressed
    q = read_box(32'h33, 6'd63, 4'd1);
    q.now_ms = clock_ms - 48'd100;                      // time running backwards
    send_request(q);
    q = post_word(32'h0, 32'hFFFF_FFFF, 3'd0, 1'b0);
    q.now_ms = 48'hFFFF_FFFF_FFFF;
    q.data_word = '1;
    send_request(q);
    q = post_word(32'h0, 32'h0, 3'd7, 1'b1);            // word beyond a short post
    q.data_word = '1;
    send_request(q);
    q = read_box(32'h33, 6'd5, 4'd1);
    q.now_ms = clock_ms + 48'd5000;                     // expires and clears
    send_request(q);
    q = post_word(32'h44, 32'h0, 3'd0, 1'b1);
    q.now_ms = '0;                                      // post at time zero
    send_request(q);
    q = blank(op_e'(3'd7));
    send_request(q);                                    // unused code

    // The shortest lifetime makes almost everything expire.
    write_lifetime(32'd1);
    stall_mode = 1;
    random_phase(10);

    // Ids run out: connect until refused.
    drain();
    while (board.next_id <= NCLI) begin
      send_request(blank(OP_CONNECT));
      if (board.next_id == NCLI) begin
        send_request(blank(OP_CONNECT));
        break;
      end
    end

    // The longest lifetime lets the table fill up and report full.
    write_lifetime(32'hFFFF_FFFF);
    stall_mode = 2;
    for (int unsigned i = 0; i < NSLOT + 2; i++)
      send_message(senders[i % 4], 32'd0, 1);
    random_phase(12);

    // Back-pressure: the receiver holds off while requests keep coming.
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      random_phase(8);
    join

    // The sender pauses until every owed result has come.
    drain();
    write_lifetime(32'd200);
    stall_mode = 0;
    random_phase(10);
    write_lifetime(EXPIRY_RESET);
    stall_mode = 1;
    random_phase(5);

    drain();
    $display("Sent %0d requests and checked %0d results, %0d of them from %0d good reads.",
             sent, board.checked, board.good_reads * NWORD, board.good_reads);
    $display("Lifetimes 1, 200, 1000 and the maximum were used, with ids exhausted.");
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
